>>> design/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and constants of the Intel HEX record checker.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int unsigned HeaderChars = 15;
  localparam int unsigned LinePosMax  = 1023;
  localparam int unsigned MinLine     = 13;
  localparam int unsigned EndLen      = 11;

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharColon = 8'h3A;

  // Both accepted header records and the end record, first character in the MSBs.
  localparam logic [8*HeaderChars-1:0] HdrOne = ":020000040800F2";
  localparam logic [8*HeaderChars-1:0] HdrTwo = ":020000040000FA";
  localparam logic [8*EndLen-1:0]      EndRec = ":00000001FF";

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LINES  = 3'b010,
    PH_STOP   = 3'b100
  } ihex_phase_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_HEADER   = 3'd1,
    ERR_LENGTH   = 3'd2,
    ERR_ADDRESS  = 3'd3,
    ERR_TYPE     = 3'd4,
    ERR_CHECKSUM = 3'd5
  } ihex_err_e;

  typedef struct packed {
    ihex_phase_e phase;
    logic [3:0]  hdr_pos;
    logic [1:0]  hdr_match;
    logic [9:0]  line_pos;
    logic        starts_colon;
    logic        end_match;
    logic [3:0]  high_nib;
    logic [7:0]  byte_cnt;
    logic [15:0] rec_addr;
    logic [7:0]  rec_type;
    logic [7:0]  run_sum;
    logic [7:0]  csum;
    logic [16:0] committed;
  } ihex_state_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [16:0] data_address;
    logic        line_done;
    logic        record_ok;
    logic        stream_done;
    ihex_err_e   error_code;
    logic [16:0] image_size;
  } ihex_res_t;

  localparam ihex_state_t StateRst = '{
    phase:        PH_HEADER,
    hdr_pos:      4'd0,
    hdr_match:    2'b11,
    line_pos:     10'd0,
    starts_colon: 1'b0,
    end_match:    1'b1,
    high_nib:     4'd0,
    byte_cnt:     8'd0,
    rec_addr:     16'd0,
    rec_type:     8'd0,
    run_sum:      8'd0,
    csum:         8'd0,
    committed:    17'd0
  };

endpackage

>>> design/ihex_intf.sv
// ----------------------------------------------------------------------------
// ihex_char_if / ihex_res_if
// Valid/ready channels for the character input and the result output.
// ----------------------------------------------------------------------------
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ihex_res_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [16:0] data_address;
  logic        line_done;
  logic        record_ok;
  logic        stream_done;
  logic [2:0]  error_code;
  logic [16:0] image_size;

  modport source (output valid, output data_valid, output data_byte, output data_address,
                  output line_done, output record_ok, output stream_done,
                  output error_code, output image_size, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input data_address,
                  input line_done, input record_ok, input stream_done,
                  input error_code, input image_size, output ready);
endinterface

>>> design/ihex_step.sv
// ----------------------------------------------------------------------------
// ihex_step
// Next-state and result logic for one character of the stream.
// ----------------------------------------------------------------------------
module ihex_step (
  input  ihex_pkg::ihex_state_t state_i,
  input  logic [7:0]            char_i,
  output ihex_pkg::ihex_state_t state_o,
  output ihex_pkg::ihex_res_t   res_o
);
  import ihex_pkg::*;

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic ihex_state_t line_clear(ihex_state_t s);
    ihex_state_t r;
    r              = s;
    r.line_pos     = 10'd0;
    r.starts_colon = 1'b0;
    r.end_match    = 1'b1;
    r.high_nib     = 4'd0;
    r.byte_cnt     = 8'd0;
    r.rec_addr     = 16'd0;
    r.rec_type     = 8'd0;
    r.run_sum      = 8'd0;
    r.csum         = 8'd0;
    return r;
  endfunction

  logic [3:0]  hp;
  logic [1:0]  flags;
  logic [9:0]  lp;
  logic [7:0]  bval;
  logic [8:0]  k;
  logic [8:0]  cnt_p4;
  logic [9:0]  exp_len;
  ihex_err_e   err;
  ihex_state_t n;
  ihex_res_t   r;

  always_comb begin
    n       = state_i;
    r       = '0;
    hp      = state_i.hdr_pos;
    flags   = state_i.hdr_match;
    lp      = state_i.line_pos;
    bval    = {state_i.high_nib, hex_val(char_i)};
    k       = lp[9:1] - 9'd1;
    cnt_p4  = {1'b0, state_i.byte_cnt} + 9'd4;
    exp_len = {1'b0, state_i.byte_cnt, 1'b0} + 10'd11;
    err     = ERR_NONE;

    case (state_i.phase)
      PH_HEADER: begin
        if (char_i == CharLf || hp >= 4'(HeaderChars)) begin
          err = ERR_HEADER;
        end else begin
          if (char_i != HdrOne[8*(HeaderChars-1-hp) +: 8]) flags[0] = 1'b0;
          if (char_i != HdrTwo[8*(HeaderChars-1-hp) +: 8]) flags[1] = 1'b0;
          n.hdr_match = flags;
          n.hdr_pos   = hp + 4'd1;
          if (hp == 4'(HeaderChars - 1)) begin
            if (flags != 2'b00) begin
              n       = line_clear(n);
              n.phase = PH_LINES;
            end else begin
              err = ERR_HEADER;
            end
          end
        end
        if (err != ERR_NONE) begin
          r.error_code = err;
          n.phase      = PH_STOP;
        end
      end
      PH_LINES: begin
        if (char_i == CharLf) begin
          if (lp == 10'(EndLen + 1) && state_i.end_match) begin
            r.stream_done = 1'b1;
            n.phase       = PH_STOP;
          end else if (state_i.starts_colon && lp >= 10'(MinLine)) begin
            r.line_done = 1'b1;
            if (lp - 10'd1 != exp_len) err = ERR_LENGTH;
            else if ({1'b0, state_i.rec_addr} != state_i.committed) err = ERR_ADDRESS;
            else if (state_i.rec_type != 8'd0) err = ERR_TYPE;
            else if (8'd0 - state_i.run_sum != state_i.csum) err = ERR_CHECKSUM;
            if (err != ERR_NONE) begin
              r.error_code = err;
              n.phase      = PH_STOP;
            end else begin
              r.record_ok = 1'b1;
              n.committed = state_i.committed + {9'd0, state_i.byte_cnt};
            end
          end
          n = line_clear(n);
        end else begin
          if (lp == 10'd0) n.starts_colon = (char_i == CharColon);
          if (lp < 10'(EndLen) && char_i != EndRec[8*(EndLen-1-lp[3:0]) +: 8]) begin
            n.end_match = 1'b0;
          end
          if (lp >= 10'd1 && lp < 10'(LinePosMax)) begin
            if (lp[0]) begin
              n.high_nib = hex_val(char_i);
            end else if (k == 9'd0) begin
              n.byte_cnt = bval;
              n.run_sum  = bval;
            end else begin
              if (k == 9'd1) n.rec_addr[15:8] = bval;
              if (k == 9'd2) n.rec_addr[7:0]  = bval;
              if (k == 9'd3) n.rec_type       = bval;
              if (k < cnt_p4) begin
                n.run_sum = state_i.run_sum + bval;
                // data bytes sit after count, address and type
                if (k >= 9'd4 && state_i.starts_colon) begin
                  r.data_valid   = 1'b1;
                  r.data_byte    = bval;
                  r.data_address = state_i.committed + {8'd0, k} - 17'd4;
                end
              end else if (k == cnt_p4) begin
                n.csum = bval;
              end
            end
          end
          if (lp < 10'(LinePosMax)) n.line_pos = lp + 10'd1;
        end
      end
      PH_STOP: begin
        n = state_i;
      end
      default: begin
        n.phase = PH_STOP;
      end
    endcase

    r.image_size = n.committed;
    state_o      = n;
    res_o        = r;
  end

endmodule

>>> design/intel_hex_record_checker_unit.sv
// ----------------------------------------------------------------------------
// intel_hex_record_checker_unit
// Checks an Intel HEX character stream and reports data bytes and record status.
// ----------------------------------------------------------------------------
// Usage:
//   char_in takes one ASCII character per beat; a line feed closes a line.
//   res_out gives exactly one result beat per character: a tentative data
//   byte with its image address, line and record status, end-of-stream,
//   an error code and the committed image size.
//   Path: an accepted character is registered in the input register, and
//   its result is then registered in the result register, from which the
//   result beat is offered on res_out.
//   Throughput: one character per cycle unless res_out stalls; each
//   character's update is one pass of logic from input to result register.
//   A stalled receiver holds the result register; one more character waits
//   in the input register, then char_in.ready drops until res_out is taken.
//   Reset empties both registers and returns to header checking; the first
//   15 characters must form one of the two accepted header records.
//   After the end record or the first error every character still yields
//   a result beat with all flags clear and the image size held.
// ----------------------------------------------------------------------------
module intel_hex_record_checker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ihex_char_if.sink   char_in,
  ihex_res_if.source  res_out
);
  import ihex_pkg::*;

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        out_valid_q;
  ihex_res_t   res_q;
  ihex_res_t   res_d;
  ihex_state_t state_q;
  ihex_state_t state_d;
  logic        adv;

  assign adv           = in_valid_q && (!out_valid_q || res_out.ready);
  assign char_in.ready = !in_valid_q || adv;

  ihex_step u_step (
    .state_i (state_q),
    .char_i  (char_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_in.valid && char_in.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_in.valid && char_in.ready) begin
      char_q <= char_in.char_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= StateRst;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_out.valid        = out_valid_q;
  assign res_out.data_valid   = res_q.data_valid;
  assign res_out.data_byte    = res_q.data_byte;
  assign res_out.data_address = res_q.data_address;
  assign res_out.line_done    = res_q.line_done;
  assign res_out.record_ok    = res_q.record_ok;
  assign res_out.stream_done  = res_q.stream_done;
  assign res_out.error_code   = res_q.error_code;
  assign res_out.image_size   = res_q.image_size;

`ifndef ASSERT_OFF
  a_stop_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_STOP |=> state_q.phase == PH_STOP)
    else $error("left stopped phase");

  a_err_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_d.error_code != ERR_NONE |=> state_q.phase == PH_STOP)
    else $error("error did not stop the stream");

  a_end_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_d.stream_done |=> state_q.phase == PH_STOP)
    else $error("end record did not stop the stream");

  a_commit_on_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !res_d.record_ok |=> $stable(state_q.committed))
    else $error("image size moved without a good record");

  a_ok_has_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.record_ok |-> res_q.line_done && res_q.error_code == ERR_NONE)
    else $error("record_ok without a clean line_done");
`endif

endmodule
